// ===== hw/rtl/sdd_pkg.sv =====
// Shared types and constants of the stream integer deduplicator.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package sdd_pkg;

   // Hash table geometry. Output field widths are fixed, so the size is fixed too.
   localparam int SLOT_BITS   = 8;
   localparam int TABLE_SLOTS = 1 << SLOT_BITS;
   localparam int COUNT_BITS  = SLOT_BITS + 1;
   localparam int VALUE_BITS  = 32;

   // Multiplier loaded at reset (golden-ratio constant).
   localparam logic [31:0] HASH_MULT_RESET = 32'h9E37_79B1;

   typedef struct packed {
      logic signed [VALUE_BITS-1:0] value;
      logic                         end_of_list;
   } req_payload_type;

   typedef struct packed {
      logic signed [VALUE_BITS-1:0] kept_value;
      logic                         is_first;
      logic [SLOT_BITS-1:0]         kept_index;
      logic                         list_done;
      logic [COUNT_BITS-1:0]        distinct_total;
      logic                         overflow;
   } rsp_payload_type;

   typedef logic [31:0] csr_payload_type;

   typedef enum logic [1:0] {
      IDLE,
      LOOKUP,
      PROBE
   } state_type;

endpackage

// ===== hw/rtl/sdd_stream_if.sv =====
// Valid/ready channel interface used by the deduplicator's request, response
// and register ports. Depends on sdd_pkg for the default payload type.
`timescale 1ns / 1ps

interface sdd_stream_if
   import sdd_pkg::*;
#(
   parameter type payload_type = csr_payload_type
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/stream_integer_deduplicator_core.sv =====
// Top level of the stream integer deduplicator: hash set with linear probing.
// Depends on sdd_pkg and on the sdd_stream_if channel interface.
`timescale 1ns / 1ps

// Usage
// Values of a list arrive on req_channel, one per transaction, the last one
// with end_of_list set. Every request transaction yields exactly one response
// transaction on rsp_channel, in order. The response tells whether the value
// is new in the current list, its index among kept values if new, the running
// distinct count and an overflow flag when a new value found every slot taken.
// The csr_channel writes the hash multiplier; it is always ready and must
// only be written while no request is in flight.
// Timing: a request is taken in the idle state, the home slot is read in the
// following cycle, and each probe is one read of the slot memory's read port.
// A new request is taken only once the current lookup has finished.
// The response sits in an output register; the next request is accepted
// while it waits. When the receiver stalls, a finished lookup holds in the
// probe state until the output register frees up.
// Reset clears the occupied bits, the count, the control state and loads the
// default multiplier. The slot memory itself is never cleared; an entry is
// only compared when its occupied bit is set. At the end of each list all
// occupied bits and the count are cleared together.

module stream_integer_deduplicator_core
   import sdd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   sdd_stream_if.sink   req_channel,
   sdd_stream_if.source rsp_channel,
   sdd_stream_if.sink   csr_channel
);

   // Only the low slot bits of the product matter, so only the low bits of
   // the multiplier are kept.
   logic [SLOT_BITS-1:0]          mult_ff;

   state_type                     state_ff;
   state_type                     state_in;

   // Item under lookup.
   logic signed [VALUE_BITS-1:0]  value_ff;
   logic                          last_ff;
   logic [SLOT_BITS-1:0]          slot_ff;
   logic [SLOT_BITS-1:0]          probe_ff;

   // Hash set storage: value memory plus occupied flags in flip-flops.
   logic [VALUE_BITS-1:0]         slot_mem [TABLE_SLOTS];
   logic [VALUE_BITS-1:0]         rd_data_ff;
   logic                          rd_occ_ff;
   logic [TABLE_SLOTS-1:0]        occupied_ff;
   logic [COUNT_BITS-1:0]         count_ff;

   rsp_payload_type               rsp_payload_ff;
   logic                          rsp_valid_ff;

   logic [2*SLOT_BITS-1:0]        product;
   logic                          req_fire;
   logic                          out_free;
   logic                          hit;
   logic                          empty;
   logic                          full;
   logic                          finish;
   logic                          finish_fire;
   logic                          advance;
   logic [SLOT_BITS-1:0]          rd_addr;

   assign req_fire = req_channel.valid && req_channel.ready;
   assign out_free = !rsp_valid_ff || rsp_channel.ready;

   // Home slot: low bits of value times multiplier, registered before use.
   assign product = req_channel.payload.value[SLOT_BITS-1:0] * mult_ff;

   // Probe outcome, valid in the probe state from the registered read data.
   assign empty  = !rd_occ_ff;
   assign hit    = rd_occ_ff && (rd_data_ff == value_ff);
   assign full   = rd_occ_ff && !hit && (probe_ff == {SLOT_BITS{1'b1}});
   assign finish = empty || hit || full;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         IDLE: begin
            if (req_fire) begin
               state_in = LOOKUP;
            end
         end
         LOOKUP: begin
            state_in = PROBE;
         end
         PROBE: begin
            if (finish && out_free) begin
               state_in = IDLE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_comb begin
      req_channel.ready = 1'b0;
      finish_fire       = 1'b0;
      advance           = 1'b0;
      rd_addr           = slot_ff;
      case (state_ff)
         IDLE: begin
            req_channel.ready = 1'b1;
         end
         LOOKUP: begin
            rd_addr = slot_ff;
         end
         PROBE: begin
            finish_fire = finish && out_free;
            advance     = !finish;
            // A stalled finish re-reads the same slot so the data stays put.
            rd_addr     = advance ? slot_ff + 1'b1 : slot_ff;
         end
         default: begin
            req_channel.ready = 1'b0;
         end
      endcase
   end

   assign csr_channel.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         mult_ff  <= HASH_MULT_RESET[SLOT_BITS-1:0];
      end else begin
         state_ff <= state_in;
         if (csr_channel.valid) begin
            mult_ff <= csr_channel.payload[SLOT_BITS-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         value_ff <= req_channel.payload.value;
         last_ff  <= req_channel.payload.end_of_list;
         slot_ff  <= product[SLOT_BITS-1:0];
         probe_ff <= '0;
      end else if (advance) begin
         slot_ff  <= slot_ff + 1'b1;
         probe_ff <= probe_ff + 1'b1;
      end
   end

   // Slot memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (finish_fire && empty) begin
         slot_mem[slot_ff] <= value_ff;
      end
      rd_data_ff <= slot_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occupied_ff <= '0;
         count_ff    <= '0;
         rd_occ_ff   <= 1'b0;
      end else begin
         rd_occ_ff <= occupied_ff[rd_addr];
         if (finish_fire && last_ff) begin
            occupied_ff <= '0;
            count_ff    <= '0;
         end else if (finish_fire && empty) begin
            occupied_ff[slot_ff] <= 1'b1;
            count_ff             <= count_ff + 1'b1;
         end
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (finish_fire) begin
         rsp_payload_ff.kept_value     <= value_ff;
         rsp_payload_ff.is_first       <= empty;
         rsp_payload_ff.kept_index     <= empty ? count_ff[SLOT_BITS-1:0] : '0;
         rsp_payload_ff.list_done      <= last_ff;
         rsp_payload_ff.distinct_total <= count_ff + {{(COUNT_BITS-1){1'b0}}, empty};
         rsp_payload_ff.overflow       <= full;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (finish_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_channel.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_channel.valid   = rsp_valid_ff;
   assign rsp_channel.payload = rsp_payload_ff;

   // A lookup never finishes onto an occupied output register.
   assert property (@(posedge clock) disable iff (reset)
      finish_fire |-> out_free)
      else $error("lookup finished while the output register was busy");

   // The end of a list leaves an empty set behind.
   assert property (@(posedge clock) disable iff (reset)
      finish_fire && last_ff |=> count_ff == '0 && occupied_ff == '0)
      else $error("set not cleared after end of list");

   // The count matches the number of occupied slots.
   assert property (@(posedge clock) disable iff (reset)
      count_ff == COUNT_BITS'($countones(occupied_ff)))
      else $error("distinct count disagrees with occupied slots");

   // A new value and an overflow never come together.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_payload_ff.is_first && rsp_payload_ff.overflow))
      else $error("response flags both first and overflow");

endmodule
